// ===== design/tccs_pkg.sv =====
package tccs_pkg;

    localparam int CELL_W     = 16;
    localparam int RESULT_CAP = 4;

    localparam logic [CELL_W-1:0] CELL_BLANK = 16'h0720;
    localparam logic [7:0]        ATTR_RESET = 8'h07;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        KIND_PUT  = 2'd0,
        KIND_VIEW = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    // One result as it leaves the engine; from_mem picks the RAM read data
    typedef struct packed {
        logic [6:0]        cell_row;
        logic [6:0]        cell_column;
        logic [CELL_W-1:0] cell_value;
        logic              write_valid;
        logic              on_screen;
        logic [4:0]        screen_row;
        logic [6:0]        view_row;
        logic [6:0]        cursor_row;
        logic [6:0]        cursor_column;
        logic              screen_cleared;
        logic              last;
        logic              from_mem;
    } res_t;

endpackage

// ===== design/text_console_cursor_scroll_top.sv =====
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall  kind, char_code, target_row, target_column
// out       result     out_valid/out_stall  cell_row ... last (one result per cycle unless stalled)
// cfg       write      cfg_write            cfg_data (text attribute)
//
// A put (not NUL or tab), newline, set-view or read request gives one result; NUL and the
// unused kind give none, and a tab gives up to min(TAB_SPACES, 4) results in a row.
// A new request is taken in the cycle its predecessor issues its last result.
// After reset a clear sweep writes blank cells over the whole store, one per cycle,
// with in_stall high.
// A held out_stall freezes the output register and the engine, and in_stall follows.
module text_console_cursor_scroll_top #(
    parameter int COLUMNS      = 80,
    parameter int VISIBLE_ROWS = 25,
    parameter int STORE_ROWS   = 128,
    parameter int TAB_SPACES   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  char_code,
    input  logic [6:0]  target_row,
    input  logic [6:0]  target_column,
    // attribute register
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  cell_row,
    output logic [6:0]  cell_column,
    output logic [15:0] cell_value,
    output logic        write_valid,
    output logic        on_screen,
    output logic [4:0]  screen_row,
    output logic [6:0]  view_row,
    output logic [6:0]  cursor_row,
    output logic [6:0]  cursor_column,
    output logic        screen_cleared,
    output logic        last
);

    import tccs_pkg::*;

    localparam int CELLS = STORE_ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic              adv;
    logic              res_valid;
    res_t              res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    // Cursor, view and attribute live in the engine; it issues at most one cell write
    // or read per cycle while the output register advances, and hands the result on to it.
    tccs_engine #(
        .COLUMNS      (COLUMNS),
        .VISIBLE_ROWS (VISIBLE_ROWS),
        .STORE_ROWS   (STORE_ROWS),
        .TAB_SPACES   (TAB_SPACES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .char_code     (char_code),
        .target_row    (target_row),
        .target_column (target_column),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .adv           (adv),
        .res_valid     (res_valid),
        .res           (res),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr)
    );

    // Cell store: a read issued in a cycle always follows any earlier write,
    // so no forwarding path is needed.
    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: merge the read data into the pending result and hold it
    // while the sink stalls.
    tccs_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (res_valid),
        .res            (res),
        .rdata          (mem_rdata),
        .adv            (adv),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_row       (cell_row),
        .cell_column    (cell_column),
        .cell_value     (cell_value),
        .write_valid    (write_valid),
        .on_screen      (on_screen),
        .screen_row     (screen_row),
        .view_row       (view_row),
        .cursor_row     (cursor_row),
        .cursor_column  (cursor_column),
        .screen_cleared (screen_cleared),
        .last           (last)
    );

endmodule

// ===== design/tccs_ram.sv =====
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tccs_engine.sv =====
module tccs_engine #(
    parameter int COLUMNS      = 80,
    parameter int VISIBLE_ROWS = 25,
    parameter int STORE_ROWS   = 128,
    parameter int TAB_SPACES   = 4,
    localparam int AW = $clog2(STORE_ROWS * COLUMNS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                kind,
    input  logic [7:0]                char_code,
    input  logic [6:0]                target_row,
    input  logic [6:0]                target_column,
    input  logic                      cfg_write,
    input  logic [7:0]                cfg_data,
    input  logic                      adv,
    output logic                      res_valid,
    output tccs_pkg::res_t            res,
    output logic                      mem_we,
    output logic [AW-1:0]             mem_waddr,
    output logic [tccs_pkg::CELL_W-1:0] mem_wdata,
    output logic                      mem_re,
    output logic [AW-1:0]             mem_raddr
);

    import tccs_pkg::*;

    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(STORE_ROWS);
    localparam int SW         = (RW + 2 > 8) ? RW + 2 : 8;
    localparam int CELLS      = STORE_ROWS * COLUMNS;
    localparam int VIEW_LIMIT = (STORE_ROWS > VISIBLE_ROWS) ? STORE_ROWS - VISIBLE_ROWS : 0;
    localparam int TAB_COUNT  = (TAB_SPACES < RESULT_CAP) ? TAB_SPACES : RESULT_CAP;
    localparam int TW         = (TAB_COUNT > 1) ? $clog2(TAB_COUNT) : 1;

    localparam logic [SW-1:0] VIS_S     = SW'(VISIBLE_ROWS);
    localparam logic [SW-1:0] ROWS_S    = SW'(STORE_ROWS);
    localparam logic [SW-1:0] LIMIT_S   = SW'(VIEW_LIMIT);
    localparam logic [CW:0]   COLS_S    = (CW + 1)'(COLUMNS);
    localparam logic [TW-1:0] TAB_LAST  = TW'(TAB_COUNT - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);

    logic [7:0]    attr_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          cur_valid_reg, cur_valid_next;
    logic [1:0]    cur_kind_reg;
    logic [7:0]    cur_char_reg;
    logic [6:0]    cur_trow_reg;
    logic [6:0]    cur_tcol_reg;
    logic [TW-1:0] tab_idx_reg, tab_idx_next;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] view_reg, view_next;

    logic          step;
    logic          accept;
    logic          keep;
    logic          cur_last;
    logic          st_we;
    logic          st_re;
    logic [AW-1:0] st_addr;
    logic [AW-1:0] rd_addr;

    assign step   = cur_valid_reg && adv;
    assign keep   = (kind == KIND_PUT && char_code != CHAR_NUL) ||
                    kind == KIND_VIEW || kind == KIND_READ;
    assign in_stall = clr_busy_reg || (cur_valid_reg && !(step && cur_last));
    assign accept = in_valid && !in_stall;

    assign st_addr = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign rd_addr = AW'(cur_trow_reg) * COLS_A + AW'(cur_tcol_reg);

    always_comb
    begin
        logic [SW-1:0] row_s;
        logic [SW-1:0] view_s;
        logic [SW-1:0] row_inc;
        logic [SW-1:0] diff;
        logic [SW-1:0] view_adv;
        logic [SW-1:0] req_view;
        logic [CW:0]   col_inc;
        logic          vis;
        logic          is_tab;
        logic          adv_row;
        logic          rd_hit;
        logic [7:0]    put_ch;

        row_s    = SW'(row_reg);
        view_s   = SW'(view_reg);
        row_inc  = row_s + SW'(1);
        diff     = row_s - view_s;
        col_inc  = (CW + 1)'(col_reg) + (CW + 1)'(1);
        vis      = (row_s >= view_s) && (diff < VIS_S);
        view_adv = (view_s + SW'(1) > LIMIT_S) ? LIMIT_S : view_s + SW'(1);
        req_view = (SW'(cur_trow_reg) > LIMIT_S) ? LIMIT_S : SW'(cur_trow_reg);
        is_tab   = cur_char_reg == CHAR_TAB;
        put_ch   = is_tab ? CHAR_SPACE : cur_char_reg;
        rd_hit   = (32'(cur_trow_reg) < STORE_ROWS) && (32'(cur_tcol_reg) < COLUMNS);
        adv_row  = 1'b0;

        row_next  = row_reg;
        col_next  = col_reg;
        view_next = view_reg;
        res       = '0;
        st_we     = 1'b0;
        st_re     = 1'b0;
        cur_last  = 1'b1;

        case (cur_kind_reg)
            KIND_PUT:
            begin
                if (cur_char_reg == CHAR_NEWLINE)
                begin
                    adv_row = 1'b1;
                end
                else
                begin
                    st_we            = 1'b1;
                    res.cell_row     = 7'(row_reg);
                    res.cell_column  = 7'(col_reg);
                    res.cell_value   = {attr_reg, put_ch};
                    res.write_valid  = 1'b1;
                    res.on_screen    = vis;
                    res.screen_row   = vis ? 5'(diff) : 5'd0;
                    if (col_inc >= COLS_S)
                    begin
                        adv_row = 1'b1;
                    end
                    else
                    begin
                        col_next = CW'(col_inc);
                    end
                    // a tab stops at the line end or after its last space
                    if (is_tab)
                    begin
                        cur_last = adv_row || (tab_idx_reg == TAB_LAST);
                    end
                end
                if (adv_row)
                begin
                    col_next = '0;
                    if (row_inc >= ROWS_S)
                    begin
                        row_next           = '0;
                        view_next          = '0;
                        res.screen_cleared = 1'b1;
                    end
                    else
                    begin
                        row_next = RW'(row_inc);
                        if (row_inc >= view_s + VIS_S)
                        begin
                            view_next = RW'(view_adv);
                        end
                    end
                end
            end
            KIND_VIEW:
            begin
                view_next = RW'(req_view);
            end
            KIND_READ:
            begin
                res.cell_row    = cur_trow_reg;
                res.cell_column = cur_tcol_reg;
                res.from_mem    = rd_hit;
                st_re           = rd_hit;
            end
            default:
            begin
            end
        endcase

        res.view_row      = 7'(view_next);
        res.cursor_row    = 7'(row_next);
        res.cursor_column = 7'(col_next);
        res.last          = cur_last;
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        tab_idx_next   = tab_idx_reg;
        if (step)
        begin
            if (cur_last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                tab_idx_next = tab_idx_reg + TW'(1);
            end
        end
        if (accept)
        begin
            cur_valid_next = keep;
            tab_idx_next   = '0;
        end
    end

    assign res_valid = cur_valid_reg;
    assign mem_we    = clr_busy_reg || (step && st_we);
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : st_addr;
    assign mem_wdata = clr_busy_reg ? CELL_BLANK : res.cell_value;
    assign mem_re    = step && st_re;
    assign mem_raddr = rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_RESET;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            cur_valid_reg <= 1'b0;
            tab_idx_reg   <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            view_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                attr_reg <= cfg_data;
            end
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == ADDR_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
            end
            cur_valid_reg <= cur_valid_next;
            tab_idx_reg   <= tab_idx_next;
            if (step)
            begin
                row_reg  <= row_next;
                col_reg  <= col_next;
                view_reg <= view_next;
            end
        end
    end

    // hold the request fields; only the valid bit needs reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_kind_reg <= kind;
            cur_char_reg <= char_code;
            cur_trow_reg <= target_row;
            cur_tcol_reg <= target_column;
        end
    end

endmodule

// ===== design/tccs_out.sv =====
module tccs_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        res_valid,
    input  tccs_pkg::res_t              res,
    input  logic [tccs_pkg::CELL_W-1:0] rdata,
    output logic                        adv,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [6:0]                  cell_row,
    output logic [6:0]                  cell_column,
    output logic [15:0]                 cell_value,
    output logic                        write_valid,
    output logic                        on_screen,
    output logic [4:0]                  screen_row,
    output logic [6:0]                  view_row,
    output logic [6:0]                  cursor_row,
    output logic [6:0]                  cursor_column,
    output logic                        screen_cleared,
    output logic                        last
);

    import tccs_pkg::*;

    logic out_valid_reg;
    res_t res_reg;

    assign adv = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && res_valid)
        begin
            res_reg <= res;
        end
    end

    // the RAM read data holds until the next read, which only issues on advance
    assign out_valid      = out_valid_reg;
    assign cell_row       = res_reg.cell_row;
    assign cell_column    = res_reg.cell_column;
    assign cell_value     = res_reg.from_mem ? rdata : res_reg.cell_value;
    assign write_valid    = res_reg.write_valid;
    assign on_screen      = res_reg.on_screen;
    assign screen_row     = res_reg.screen_row;
    assign view_row       = res_reg.view_row;
    assign cursor_row     = res_reg.cursor_row;
    assign cursor_column  = res_reg.cursor_column;
    assign screen_cleared = res_reg.screen_cleared;
    assign last           = res_reg.last;

endmodule

// ===== test/console_cell_checker.sv =====
module console_cell_checker #(
    parameter int COLUMNS      = 80,
    parameter int VISIBLE_ROWS = 25,
    parameter int STORE_ROWS   = 128,
    parameter int TAB_SPACES   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  char_code,
    input  logic [6:0]  target_row,
    input  logic [6:0]  target_column,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [6:0]  cell_row,
    input  logic [6:0]  cell_column,
    input  logic [15:0] cell_value,
    input  logic        write_valid,
    input  logic        on_screen,
    input  logic [4:0]  screen_row,
    input  logic [6:0]  view_row,
    input  logic [6:0]  cursor_row,
    input  logic [6:0]  cursor_column,
    input  logic        screen_cleared,
    input  logic        last,
    output int          error_count,
    output int          pending
);

    import tccs_pkg::*;

    localparam int VIEW_MAX   = (STORE_ROWS > VISIBLE_ROWS) ? STORE_ROWS - VISIBLE_ROWS : 0;
    localparam int CELL_TOTAL = STORE_ROWS * COLUMNS;

    typedef struct packed {
        logic [6:0]  cell_row;
        logic [6:0]  cell_column;
        logic [15:0] cell_value;
        logic        write_valid;
        logic        on_screen;
        logic [4:0]  screen_row;
        logic [6:0]  view_row;
        logic [6:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic        screen_cleared;
        logic        last;
    } console_cell_t;

    logic [15:0]   shadow_store [CELL_TOTAL];
    int unsigned   cur_row;
    int unsigned   cur_col;
    int unsigned   view_top;
    logic [7:0]    text_attr;
    console_cell_t expected_cells [$];

    function automatic int unsigned clamp_view(input int unsigned request);
        return (request > VIEW_MAX) ? VIEW_MAX : request;
    endfunction

    // new row; returns 1 when the cursor ran off the end of the store
    function automatic bit step_row();
        cur_col = 0;
        cur_row++;
        if (cur_row >= view_top + VISIBLE_ROWS)
            view_top = clamp_view(view_top + 1);
        if (cur_row >= STORE_ROWS)
        begin
            cur_row  = 0;
            cur_col  = 0;
            view_top = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_result(input int unsigned row, input int unsigned col,
                                        input int unsigned value, input bit wrote,
                                        input bit vis, input int unsigned srow,
                                        input bit cleared, input bit is_last);
        console_cell_t r;
        r.cell_row       = 7'(row);
        r.cell_column    = 7'(col);
        r.cell_value     = 16'(value);
        r.write_valid    = wrote;
        r.on_screen      = vis;
        r.screen_row     = 5'(srow);
        r.view_row       = 7'(view_top);
        r.cursor_row     = 7'(cur_row);
        r.cursor_column  = 7'(cur_col);
        r.screen_cleared = cleared;
        r.last           = is_last;
        expected_cells.push_back(r);
    endfunction

    function automatic void write_cell(input logic [7:0] ch, input bit is_last);
        int unsigned row;
        int unsigned col;
        int unsigned srow;
        logic [15:0] value;
        bit          vis;
        bit          cleared;
        row     = cur_row;
        col     = cur_col;
        value   = {text_attr, ch};
        vis     = 1'b0;
        srow    = 0;
        cleared = 1'b0;
        if (row < STORE_ROWS && col < COLUMNS)
            shadow_store[row * COLUMNS + col] = value;
        if (row >= view_top && row - view_top < VISIBLE_ROWS)
        begin
            vis  = 1'b1;
            srow = row - view_top;
        end
        cur_col++;
        if (cur_col >= COLUMNS)
            cleared = step_row();
        push_result(row, col, value, 1'b1, vis, srow, cleared, is_last);
    endfunction

    function automatic void predict_request(input logic [1:0] k, input logic [7:0] ch,
                                            input logic [6:0] trow, input logic [6:0] tcol);
        int unsigned count;
        int unsigned value;
        bit          cleared;
        if (k == KIND_PUT)
        begin
            if (ch == CHAR_NEWLINE)
            begin
                cleared = step_row();
                push_result(0, 0, 0, 1'b0, 1'b0, 0, cleared, 1'b1);
            end
            else if (ch == CHAR_TAB)
            begin
                count = TAB_SPACES;
                if (count > COLUMNS - cur_col)
                    count = COLUMNS - cur_col;
                if (count > RESULT_CAP)
                    count = RESULT_CAP;
                for (int i = 0; i < count; i++)
                    write_cell(CHAR_SPACE, i == count - 1);
            end
            else if (ch != CHAR_NUL)
                write_cell(ch, 1'b1);
        end
        else if (k == KIND_VIEW)
        begin
            view_top = clamp_view(trow);
            push_result(0, 0, 0, 1'b0, 1'b0, 0, 1'b0, 1'b1);
        end
        else if (k == KIND_READ)
        begin
            value = 0;
            if (trow < STORE_ROWS && tcol < COLUMNS)
                value = shadow_store[trow * COLUMNS + tcol];
            push_result(trow, tcol, value, 1'b0, 1'b0, 0, 1'b0, 1'b1);
        end
    endfunction

    function automatic void check_field(input string field_name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
            error_count++;
        end
    endfunction

    function automatic void compare_result();
        console_cell_t want;
        if (expected_cells.size() == 0)
        begin
            $error("result with nothing pending: row %0d column %0d value 0x%0h",
                   cell_row, cell_column, cell_value);
            error_count++;
            return;
        end
        want = expected_cells.pop_front();
        check_field("cell_row", want.cell_row, cell_row);
        check_field("cell_column", want.cell_column, cell_column);
        check_field("cell_value", want.cell_value, cell_value);
        check_field("write_valid", want.write_valid, write_valid);
        check_field("on_screen", want.on_screen, on_screen);
        check_field("screen_row", want.screen_row, screen_row);
        check_field("view_row", want.view_row, view_row);
        check_field("cursor_row", want.cursor_row, cursor_row);
        check_field("cursor_column", want.cursor_column, cursor_column);
        check_field("screen_cleared", want.screen_cleared, screen_cleared);
        check_field("last", want.last, last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_TOTAL; i++)
                shadow_store[i] = CELL_BLANK;
            cur_row     = 0;
            cur_col     = 0;
            view_top    = 0;
            text_attr   = ATTR_RESET;
            error_count = 0;
            expected_cells.delete();
        end
        else
        begin
            // a result always stems from an earlier request, so check before predicting
            if (out_valid && !out_stall)
                compare_result();
            if (cfg_write)
                text_attr = cfg_data;
            if (in_valid && !in_stall)
                predict_request(kind, char_code, target_row, target_column);
        end
        pending = expected_cells.size();
    end

endmodule

// ===== test/testbench.sv =====
// Stimulus and verdict for the text console engine. The checker beside the block
// watches both channels and the attribute port, predicts every result and counts
// mismatches; this module only drives reset, requests, stalls and attribute writes.
module testbench;

    import tccs_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int VISIBLE_ROWS = 25;
    localparam int STORE_ROWS   = 128;
    localparam int TAB_SPACES   = 4;

    // The clear sweep after reset runs with no request taken, so the watchdog limit
    // sits well above the cell count of the store.
    localparam int WATCHDOG_LIMIT = 50000;
    // Settle time once the pending count hits zero; covers NUL and unused-kind
    // requests, which leave nothing to wait for but may still be in flight.
    localparam int HOLD_OFF       = 32;
    // A phase stops only after its last sequence, which runs past the quota by
    // about twenty requests on average.
    localparam int PHASE_ITEMS    = 70;

    // the unused kind code; the block ignores it
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [1:0]  kind          = KIND_PUT;
    logic [7:0]  char_code     = CHAR_NUL;
    logic [6:0]  target_row    = '0;
    logic [6:0]  target_column = '0;
    logic        cfg_write     = 1'b0;
    logic [7:0]  cfg_data      = '0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [6:0]  cell_row;
    logic [6:0]  cell_column;
    logic [15:0] cell_value;
    logic        write_valid;
    logic        on_screen;
    logic [4:0]  screen_row;
    logic [6:0]  view_row;
    logic [6:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        screen_cleared;
    logic        last;

    int error_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    text_console_cursor_scroll_top #(
        .COLUMNS      (COLUMNS),
        .VISIBLE_ROWS (VISIBLE_ROWS),
        .STORE_ROWS   (STORE_ROWS),
        .TAB_SPACES   (TAB_SPACES)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .char_code      (char_code),
        .target_row     (target_row),
        .target_column  (target_column),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_row       (cell_row),
        .cell_column    (cell_column),
        .cell_value     (cell_value),
        .write_valid    (write_valid),
        .on_screen      (on_screen),
        .screen_row     (screen_row),
        .view_row       (view_row),
        .cursor_row     (cursor_row),
        .cursor_column  (cursor_column),
        .screen_cleared (screen_cleared),
        .last           (last)
    );

    console_cell_checker #(
        .COLUMNS      (COLUMNS),
        .VISIBLE_ROWS (VISIBLE_ROWS),
        .STORE_ROWS   (STORE_ROWS),
        .TAB_SPACES   (TAB_SPACES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .char_code      (char_code),
        .target_row     (target_row),
        .target_column  (target_column),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_row       (cell_row),
        .cell_column    (cell_column),
        .cell_value     (cell_value),
        .write_valid    (write_valid),
        .on_screen      (on_screen),
        .screen_row     (screen_row),
        .view_row       (view_row),
        .cursor_row     (cursor_row),
        .cursor_column  (cursor_column),
        .screen_cleared (screen_cleared),
        .last           (last),
        .error_count    (error_count),
        .pending        (pending)
    );

    // Receiver back-pressure: redraw the stall at each falling edge at the rate of the
    // current phase. A rate of zero keeps the result channel wide open.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Watchdog: any accepted request or result rearms it. A hung handshake or a lost
    // result ends the run here.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one request and hold it until accepted. Called at a falling edge and
    // returns at a falling edge. The idle draw comes first, so valid drops only when a
    // gap is actually taken and is never lowered and raised in the same step.
    task automatic send_request(input logic [1:0] k, input logic [7:0] ch,
                                input logic [6:0] row, input logic [6:0] col);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        kind          = k;
        char_code     = ch;
        target_row    = row;
        target_column = col;
        do
            @(posedge clk);
        while (in_stall);
        // NUL and the unused kind are dropped by the block; do not count them
        if (!(k == KIND_UNUSED || (k == KIND_PUT && ch == CHAR_NUL)))
            items_sent++;
        @(negedge clk);
    endtask

    // unused fields of a put still carry random bits
    task automatic send_put(input logic [7:0] ch);
        send_request(KIND_PUT, ch, 7'($urandom_range(127)), 7'($urandom_range(127)));
    endtask

    task automatic send_view(input logic [6:0] row);
        send_request(KIND_VIEW, 8'($urandom_range(255)), row, 7'($urandom_range(127)));
    endtask

    task automatic send_read(input logic [6:0] row, input logic [6:0] col);
        send_request(KIND_READ, 8'($urandom_range(255)), row, col);
    endtask

    // Drop valid and hold off until every predicted result is back, then let the
    // block settle. Attribute writes only happen right after this.
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_write = 1'b1;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Any byte, with tabs made common; newline and NUL turn up at their natural rate.
    function automatic logic [7:0] text_char();
        if ($urandom_range(99) < 12)
            return CHAR_TAB;
        return 8'($urandom_range(255));
    endfunction

    // a byte that is written as a cell and never acts as a control
    function automatic logic [7:0] printable_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(255));
        while (ch == CHAR_NUL || ch == CHAR_TAB || ch == CHAR_NEWLINE);
        return ch;
    endfunction

    // Start a fresh row, fill it to within a few columns of the end (or past it) and
    // close with a tab, so the tab may be cut short at the line end or land after a wrap.
    task automatic fill_line();
        int len;
        send_put(CHAR_NEWLINE);
        len = $urandom_range(74, 80);
        repeat (len) send_put(printable_char());
        send_put(CHAR_TAB);
    endtask

    // Random traffic, built from short sequences. Newline bursts dominate so the
    // cursor walks down past the view (follow scroll), into the clamp at the bottom of
    // the store and across the store end; text runs and full lines exercise the
    // column wrap, and reads pull back cells written earlier.
    task automatic run_phase(input int quota);
        int first;
        int pick;
        int len;
        first = items_sent;
        while (items_sent - first < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
            begin
                len = $urandom_range(3, 30);
                repeat (len) send_put(CHAR_NEWLINE);
            end
            else if (pick < 62)
            begin
                len = $urandom_range(1, 30);
                repeat (len) send_put(text_char());
            end
            else if (pick < 70)
                fill_line();
            else if (pick < 81)
            begin
                // pull the view home now and then so later writes show on screen
                if ($urandom_range(2) == 0)
                    send_view('0);
                else
                    send_view(7'($urandom_range(127)));
            end
            else if (pick < 93)
            begin
                // mostly the rows near the top, where most writes land; some columns
                // past the line end
                if ($urandom_range(1) == 0)
                    len = $urandom_range(8);
                else
                    len = $urandom_range(127);
                if ($urandom_range(4) == 0)
                    send_read(7'(len), 7'($urandom_range(80, 127)));
                else
                    send_read(7'(len), 7'($urandom_range(79)));
            end
            else if (pick < 97)
            begin
                // junk the block must swallow without a result
                if ($urandom_range(1) == 0)
                    send_put(CHAR_NUL);
                else
                    send_request(KIND_UNUSED, 8'($urandom_range(255)),
                                 7'($urandom_range(127)), 7'($urandom_range(127)));
            end
            else
                drain_results();
        end
    endtask

    initial
    begin
        logic [7:0] attr;

        // hold reset, then release it on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, at the reset attribute. The first request waits out the clear
        // sweep through in_stall.
        send_put(8'h41);
        send_put(8'hFF);
        send_put(8'h80);
        send_put(CHAR_NUL);                 // dropped, no result
        send_put(CHAR_TAB);                 // full four spaces
        send_put(8'h01);
        send_put(CHAR_NEWLINE);
        send_read('0, '0);                  // cell written above
        send_read('0, 7'd6);                // last space of the tab
        send_read(7'd127, 7'd79);           // far corner, still blank
        send_read('0, 7'd80);               // column past the line end reads zero
        send_read(7'h7F, 7'h7F);
        send_view(7'h7F);                   // saturates at the highest offset
        send_put(8'h7E);                    // cursor row now above the view
        send_put(CHAR_NEWLINE);             // no follow scroll from above the view
        send_view(7'd103);
        send_view(7'd104);
        send_view('0);
        send_request(KIND_UNUSED, 8'hFF, 7'h7F, 7'h7F);
        send_put(CHAR_TAB);
        send_put(CHAR_NEWLINE);
        send_view(7'd1);                    // view starts below row 0
        send_put(8'h55);
        send_read(7'd1, '0);

        // Four phases of random traffic, each at its own idle mix and attribute.
        // Every phase starts drained, so the attribute write lands on an idle block.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    attr           = 8'h00;
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                    attr           = 8'hFF;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                    attr           = 8'($urandom_range(255));
                end
                default:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                    attr           = 8'h1E;
                end
            endcase
            drain_results();
            write_attribute(attr);
            run_phase(PHASE_ITEMS);
        end

        // wait out every pending result and let the block settle before the verdict
        drain_results();
        if (error_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
